// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	// Queue geometry.
	localparam int QueueDepth = 16;
	localparam int TagWidth   = 32;
	localparam int PrioWidth  = 16;
	localparam int CountWidth = $clog2(QueueDepth + 1);

	// Command codes of a request.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// Status codes of a response.
	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_POP_EMPTY   = 2'd1,
		STAT_INSERT_FULL = 2'd2,
		STAT_CLEAR_EMPTY = 2'd3
	} status_t;

	// Request payload.
	typedef struct packed {
		logic [1:0]         command;
		logic [31:0]        payload;
		logic signed [15:0] priority_req;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic [31:0]        head_payload;
		logic signed [15:0] head_priority;
		logic               head_valid;
		logic [4:0]         fill_count;
		logic [1:0]         status;
	} rsp_t;

	// One queue entry as held in a cell.
	typedef struct packed {
		logic [TagWidth-1:0]         tag;
		logic signed [PrioWidth-1:0] prio;
	} entry_t;

	// Per-cell control from the top level and the left neighbor.
	typedef struct packed {
		logic ins;       // an insert that fits is applied this cycle
		logic pop;       // a pop on a non-empty queue is applied this cycle
		logic occupied;  // this cell holds a live entry
		logic prev_gt;   // left neighbor stays ahead of the new entry
	} cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output logic               gt,
	output spq_pkg::entry_t    entry_d,
	output spq_pkg::entry_t    entry_q
);

	// The held entry stays ahead of the new one only on strictly greater priority.
	assign gt = ctl.occupied && (entry_q.prio > new_entry.prio);

	// Insert: keep, take the new entry at the boundary, or shift right.
	// Pop: shift left.
	always_comb begin
		entry_d = entry_q;
		if (ctl.ins) begin
			if (!gt) begin
				entry_d = ctl.prev_gt ? new_entry : prev_entry;
			end
		end else if (ctl.pop) begin
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// File: rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps

// Sorted priority queue of 16 entries held in a row of cells, head in cell 0.
// On an insert all cells compare their priority with the new entry in parallel
// and shift right by one place; on a pop they shift left by one place; a clear
// only resets the fill count. A new request is accepted every cycle unless the
// response register is still holding a response that is not being taken. Each
// request yields exactly one response, showing the head entry, the fill count
// and a status after the request, registered in the cycle after acceptance.

module sorted_priority_queue_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	localparam int Depth = spq_pkg::QueueDepth;
	localparam int CW    = spq_pkg::CountWidth;

	logic                accept;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic                is_full;
	logic                is_empty;
	spq_pkg::status_t    status_d;
	logic                do_ins;
	logic                do_pop;
	spq_pkg::entry_t     new_entry;
	spq_pkg::entry_t     cell_q [Depth];
	spq_pkg::entry_t     cell_d [Depth];
	logic [Depth-1:0]    cell_gt;
	logic                rsp_valid_q;
	spq_pkg::rsp_t       rsp_q;

	// Handshake: accept whenever the response register is free or being taken.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_full  = (count_q == CW'(Depth));
	assign is_empty = (count_q == '0);

	assign new_entry.tag  = req.payload;
	assign new_entry.prio = req.priority_req;

	// Command decode, status and next fill count.
	always_comb begin
		do_ins   = 1'b0;
		do_pop   = 1'b0;
		count_d  = count_q;
		status_d = spq_pkg::STAT_OK;
		case (spq_pkg::cmd_t'(req.command))
			spq_pkg::CMD_INSERT: begin
				if (is_full) begin
					status_d = spq_pkg::STAT_INSERT_FULL;
				end else begin
					do_ins  = accept;
					count_d = count_q + CW'(1);
				end
			end
			spq_pkg::CMD_POP: begin
				if (is_empty) begin
					status_d = spq_pkg::STAT_POP_EMPTY;
				end else begin
					do_pop  = accept;
					count_d = count_q - CW'(1);
				end
			end
			spq_pkg::CMD_CLEAR: begin
				if (is_empty) begin
					status_d = spq_pkg::STAT_CLEAR_EMPTY;
				end else begin
					count_d = '0;
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// Row of cells; each sees its neighbors and the broadcast new entry.
	for (genvar i = 0; i < Depth; i++) begin : g_cell
		spq_pkg::cell_ctl_t ctl;
		spq_pkg::entry_t    prev_e;
		spq_pkg::entry_t    next_e;

		assign ctl.ins      = do_ins;
		assign ctl.pop      = do_pop;
		assign ctl.occupied = (count_q > CW'(i));
		if (i == 0) begin : g_first
			assign ctl.prev_gt = 1'b1;
			assign prev_e      = new_entry;
		end else begin : g_inner
			assign ctl.prev_gt = cell_gt[i-1];
			assign prev_e      = cell_q[i-1];
		end
		if (i == Depth - 1) begin : g_last
			assign next_e = cell_q[i];
		end else begin : g_more
			assign next_e = cell_q[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.gt         (cell_gt[i]),
			.entry_d    (cell_d[i]),
			.entry_q    (cell_q[i])
		);
	end

	// Fill count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, built from the state after the request.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.head_valid    <= (count_d != '0);
			rsp_q.head_payload  <= (count_d != '0) ? cell_d[0].tag : '0;
			rsp_q.head_priority <= (count_d != '0) ? cell_d[0].prio : '0;
			rsp_q.fill_count    <= 5'(count_d);
			rsp_q.status        <= status_d;
		end
	end

	// The count never goes past the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("fill count beyond queue depth");

	// A shown response reports a head exactly when entries are held.
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.head_valid == (rsp_q.fill_count != 5'd0)))
		else $error("head valid disagrees with fill count");

	// An accepted pop on a non-empty queue removes exactly one entry.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command == spq_pkg::CMD_POP && !is_empty)
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not remove one entry");

	// The two front cells stay in descending priority order.
	a_sorted_front: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
		else $error("queue front out of order");

endmodule

// File: tb/sorted_priority_queue_core_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_core_test;

	// Cycles without any accepted request or response before the run is abandoned.
	localparam int IdleLimit = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	spq_pkg::req_t         req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	spq_pkg::rsp_t         rsp;

	// Shadow copy of the queue contents, head in slot 0.
	logic [spq_pkg::TagWidth-1:0]         shadow_tag  [spq_pkg::QueueDepth];
	logic signed [spq_pkg::PrioWidth-1:0] shadow_prio [spq_pkg::QueueDepth];
	int                                   shadow_fill;

	// Responses predicted for accepted requests, oldest first.
	spq_pkg::rsp_t pending_rsp [$];

	// Idle rates in percent, and the length of a forced receiver hold.
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_left;

	// Bookkeeping.
	int fail_count;
	int mismatch_count;
	int quiet_cycles;
	int cmd_seen [4];
	int status_seen [4];
	int peak_fill;
	int rsp_checked;

	sorted_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one request to the shadow queue and returns the response it should produce.
	function automatic spq_pkg::rsp_t queue_apply(spq_pkg::req_t r);
		spq_pkg::rsp_t    res;
		spq_pkg::status_t st;
		int               pos;
		st = spq_pkg::STAT_OK;
		case (r.command)
			spq_pkg::CMD_INSERT: begin
				if (shadow_fill == spq_pkg::QueueDepth) begin
					st = spq_pkg::STAT_INSERT_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_fill && shadow_prio[pos] > $signed(r.priority_req))
						pos++;
					for (int i = shadow_fill; i > pos; i--) begin
						shadow_tag[i]  = shadow_tag[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_tag[pos]  = r.payload;
					shadow_prio[pos] = $signed(r.priority_req);
					shadow_fill++;
				end
			end
			spq_pkg::CMD_POP: begin
				if (shadow_fill == 0) begin
					st = spq_pkg::STAT_POP_EMPTY;
				end else begin
					for (int i = 1; i < shadow_fill; i++) begin
						shadow_tag[i-1]  = shadow_tag[i];
						shadow_prio[i-1] = shadow_prio[i];
					end
					shadow_fill--;
				end
			end
			spq_pkg::CMD_CLEAR: begin
				if (shadow_fill == 0)
					st = spq_pkg::STAT_CLEAR_EMPTY;
				else
					shadow_fill = 0;
			end
			default: begin
				st = spq_pkg::STAT_OK;
			end
		endcase
		res = '0;
		if (shadow_fill > 0) begin
			res.head_payload  = shadow_tag[0];
			res.head_priority = shadow_prio[0];
			res.head_valid    = 1'b1;
		end
		res.fill_count = shadow_fill[4:0];
		res.status     = st;
		return res;
	endfunction

	// Compares one accepted response with the oldest prediction.
	task automatic check_response(spq_pkg::rsp_t got);
		spq_pkg::rsp_t want;
		if (pending_rsp.size() == 0) begin
			fail_count++;
			mismatch_count++;
			if (mismatch_count <= 10)
				$display({"%0t: response with no request outstanding: ",
					"payload %h prio %0d valid %b fill %0d status %0d"},
					$time, got.head_payload, got.head_priority, got.head_valid,
					got.fill_count, got.status);
		end else begin
			want = pending_rsp.pop_front();
			rsp_checked++;
			if (got.head_payload !== want.head_payload ||
			    got.head_priority !== want.head_priority ||
			    got.head_valid !== want.head_valid ||
			    got.fill_count !== want.fill_count ||
			    got.status !== want.status) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"%0t: mismatch: expected payload %h prio %0d valid %b ",
						"fill %0d status %0d, got payload %h prio %0d valid %b ",
						"fill %0d status %0d"},
						$time, want.head_payload, want.head_priority, want.head_valid,
						want.fill_count, want.status, got.head_payload, got.head_priority,
						got.head_valid, got.fill_count, got.status);
			end
		end
	endtask

	// Watches both channels at every rising edge: predicts, checks and guards against hangs.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				pending_rsp.push_back(queue_apply(req));
				cmd_seen[req.command]++;
				status_seen[pending_rsp[$].status]++;
				if (shadow_fill > peak_fill)
					peak_fill = shadow_fill;
			end
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IdleLimit) begin
				$display("Timeout: no request or response accepted for %0d cycles.", IdleLimit);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Response side: random stalls, or a forced hold when one is requested.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rsp_stall = 1'b1;
				rx_hold_left--;
			end else begin
				rsp_stall = ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic spq_pkg::req_t make_req(spq_pkg::cmd_t c, logic [31:0] tag,
		logic signed [15:0] prio);
		spq_pkg::req_t r;
		r.command      = c;
		r.payload      = tag;
		r.priority_req = prio;
		return r;
	endfunction

	// Builds a random request; the weights steer the queue toward filling or draining.
	function automatic spq_pkg::req_t random_req(int insert_pct, int pop_pct);
		spq_pkg::req_t r;
		int            pick;
		pick = $urandom_range(99);
		if (pick < insert_pct)
			r.command = spq_pkg::CMD_INSERT;
		else if (pick < insert_pct + pop_pct)
			r.command = spq_pkg::CMD_POP;
		else if (pick < insert_pct + pop_pct + 4)
			r.command = spq_pkg::CMD_CLEAR;
		else
			r.command = spq_pkg::CMD_NOP;
		case ($urandom_range(9))
			0:       r.payload = '0;
			1:       r.payload = '1;
			default: r.payload = $urandom;
		endcase
		// Few distinct priorities exercise the ordering of equal entries.
		case ($urandom_range(9))
			0, 1, 2, 3: r.priority_req = 16'($urandom);
			4, 5, 6:    r.priority_req = 16'($signed($urandom_range(3)) - 1);
			7:          r.priority_req = 16'sh7fff;
			8:          r.priority_req = 16'sh8000;
			default:    r.priority_req = 16'($signed($urandom_range(7)) - 4);
		endcase
		return r;
	endfunction

	// Offers one request and returns at the falling edge after it was taken.
	task automatic send_request(spq_pkg::req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Stops offering and waits for every outstanding response.
	task automatic drain_responses();
		req_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	// Empty-queue cases, extreme fields, equal priorities, a full queue and clearing.
	task automatic test_directed();
		send_request(make_req(spq_pkg::CMD_POP, 32'h0, 16'sh0));
		send_request(make_req(spq_pkg::CMD_CLEAR, 32'h0, 16'sh0));
		send_request(make_req(spq_pkg::CMD_NOP, 32'hffffffff, 16'sh7fff));
		send_request(make_req(spq_pkg::CMD_INSERT, 32'h00000000, 16'sh0000));
		send_request(make_req(spq_pkg::CMD_INSERT, 32'hffffffff, 16'sh7fff));
		send_request(make_req(spq_pkg::CMD_INSERT, 32'ha5a5a5a5, 16'sh8000));
		send_request(make_req(spq_pkg::CMD_INSERT, 32'h11111111, 16'sh0000));
		send_request(make_req(spq_pkg::CMD_INSERT, 32'h22222222, -16'sd1));
		for (int i = 0; i < spq_pkg::QueueDepth - 5; i++)
			send_request(make_req(spq_pkg::CMD_INSERT, $urandom,
				16'($signed($urandom_range(7)) - 3)));
		send_request(make_req(spq_pkg::CMD_INSERT, 32'h33333333, 16'sh7fff));
		send_request(make_req(spq_pkg::CMD_NOP, 32'h0, 16'sh0));
		send_request(make_req(spq_pkg::CMD_POP, 32'h0, 16'sh0));
		send_request(make_req(spq_pkg::CMD_CLEAR, 32'h0, 16'sh0));
		send_request(make_req(spq_pkg::CMD_POP, 32'h0, 16'sh0));
		drain_responses();
	endtask

	// Alternating fill and drain phases; two of them run without any idling.
	task automatic test_random();
		for (int seg = 0; seg < 10; seg++) begin
			if (seg == 2 || seg == 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = 19;
				rx_idle_pct = 19;
			end
			for (int n = 0; n < 45; n++) begin
				if (seg % 2 == 0)
					send_request(random_req(75, 15));
				else
					send_request(random_req(25, 65));
			end
		end
		drain_responses();
	endtask

	// The receiver holds off while requests keep coming, so the block stalls its input.
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_idle_pct  = 19;
		rx_hold_left = 80;
		for (int n = 0; n < 24; n++)
			send_request(random_req(70, 20));
		drain_responses();
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		tx_idle_pct    = 19;
		rx_idle_pct    = 19;
		rx_hold_left   = 0;
		shadow_fill    = 0;
		fail_count     = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		peak_fill      = 0;
		rsp_checked    = 0;
		cmd_seen       = '{default: 0};
		status_seen    = '{default: 0};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random();
		test_backpressure();

		repeat (4) @(negedge clk);
		$display("Checked %0d responses: %0d inserts, %0d pops, %0d clears, %0d no-ops; peak fill %0d.",
			rsp_checked, cmd_seen[spq_pkg::CMD_INSERT], cmd_seen[spq_pkg::CMD_POP],
			cmd_seen[spq_pkg::CMD_CLEAR], cmd_seen[spq_pkg::CMD_NOP], peak_fill);
		$display("Dropped inserts on full: %0d, pops on empty: %0d, clears on empty: %0d.",
			status_seen[spq_pkg::STAT_INSERT_FULL], status_seen[spq_pkg::STAT_POP_EMPTY],
			status_seen[spq_pkg::STAT_CLEAR_EMPTY]);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
